// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, sizes and codes for the stable priority queue unit.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PEND_W      = 5;
    localparam int PROD_W      = 16;
    localparam int QTY_W       = 16;
    localparam int PRIO_W      = 8;
    localparam int KIND_W      = 2;
    localparam int STAT_W      = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [PEND_W-1:0] t_pend;

    typedef struct packed {
        logic [PROD_W-1:0] product;
        logic [QTY_W-1:0]  quantity;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

endpackage

// ===== hdl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: accepts a transaction, schedules its execution and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output spq_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_capture;
    logic w_exec;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_capture   = i_in_valid && o_in_ready;
    assign w_exec      = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_cmd.capture = w_capture;
    assign o_cmd.exec    = w_exec;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_exec) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_capture_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_capture |=> (r_state == S_EXEC))
        else $error("Accepted transaction did not move to execution.");

    a_exec_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && r_out_valid && !i_out_ready) |=> (r_state == S_EXEC))
        else $error("Execution left while the result register was occupied.");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("Execution did not present a result.");

endmodule

// ===== hdl/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted shift-register queue with parallel priority compare, the input
// holding registers and the result register.
// ----------------------------------------------------------------------------
module spq_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spq_pkg::t_cmd               i_cmd,
    input  logic [spq_pkg::KIND_W-1:0]  i_kind,
    input  logic [spq_pkg::PROD_W-1:0]  i_order_product,
    input  logic [spq_pkg::QTY_W-1:0]   i_order_quantity,
    input  logic [spq_pkg::PRIO_W-1:0]  i_order_priority,
    output logic                        o_popped_valid,
    output logic [spq_pkg::PROD_W-1:0]  o_popped_product,
    output logic [spq_pkg::QTY_W-1:0]   o_popped_quantity,
    output logic [spq_pkg::PRIO_W-1:0]  o_popped_priority,
    output logic [spq_pkg::STAT_W-1:0]  o_status,
    output logic [spq_pkg::PEND_W-1:0]  o_pending_count
);

    logic [spq_pkg::KIND_W-1:0] r_kind;
    spq_pkg::t_entry            r_new;
    spq_pkg::t_entry            r_slot [spq_pkg::QUEUE_DEPTH];
    spq_pkg::t_entry            n_slot [spq_pkg::QUEUE_DEPTH];
    spq_pkg::t_cnt              r_count;
    spq_pkg::t_cnt              n_count;

    logic                       r_popped_valid;
    spq_pkg::t_entry            r_popped;
    logic [spq_pkg::STAT_W-1:0] r_status;
    spq_pkg::t_pend             r_pending;

    logic                       n_popped_valid;
    spq_pkg::t_entry            n_popped;
    logic [spq_pkg::STAT_W-1:0] n_status;

    logic [spq_pkg::QUEUE_DEPTH-1:0] w_ge;
    logic [spq_pkg::QUEUE_DEPTH-1:0] w_ge_prev;
    logic                            w_full;
    logic                            w_empty;
    logic                            w_do_insert;
    logic                            w_do_pop;

    assign w_full      = (r_count == spq_pkg::t_cnt'(spq_pkg::QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_do_insert = (r_kind == spq_pkg::KIND_INSERT) && !w_full;
    assign w_do_pop    = (r_kind == spq_pkg::KIND_POP) && !w_empty;

    for (genvar k = 0; k < spq_pkg::QUEUE_DEPTH; k++) begin : g_cmp
        assign w_ge[k] = (spq_pkg::t_cnt'(k) < r_count) &&
                         (r_slot[k].prio >= r_new.prio);
    end

    if (spq_pkg::QUEUE_DEPTH > 1) begin : g_prev
        assign w_ge_prev = {w_ge[spq_pkg::QUEUE_DEPTH-2:0], 1'b1};
    end else begin : g_prev_one
        assign w_ge_prev = 1'b1;
    end

    for (genvar k = 0; k < spq_pkg::QUEUE_DEPTH; k++) begin : g_slot
        spq_pkg::t_entry w_below;
        spq_pkg::t_entry w_above;
        if (k == 0) begin : g_first
            assign w_above = r_new;
        end else begin : g_mid
            assign w_above = r_slot[k-1];
        end
        if (k == spq_pkg::QUEUE_DEPTH - 1) begin : g_last
            assign w_below = r_slot[k];
        end else begin : g_rest
            assign w_below = r_slot[k+1];
        end
        always_comb begin
            n_slot[k] = r_slot[k];
            if (w_do_insert) begin
                if (w_ge[k]) begin
                    n_slot[k] = r_slot[k];
                end else if (w_ge_prev[k]) begin
                    n_slot[k] = r_new;
                end else begin
                    n_slot[k] = w_above;
                end
            end else if (w_do_pop) begin
                n_slot[k] = w_below;
            end
        end
    end

    always_comb begin
        n_count        = r_count;
        n_status       = spq_pkg::ST_OK;
        n_popped_valid = 1'b0;
        n_popped       = '0;
        unique case (r_kind)
            spq_pkg::KIND_INSERT: begin
                if (w_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + spq_pkg::t_cnt'(1);
                end
            end
            spq_pkg::KIND_POP: begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_popped_valid = 1'b1;
                    n_popped       = r_slot[0];
                    n_count        = r_count - spq_pkg::t_cnt'(1);
                end
            end
            spq_pkg::KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind         <= i_kind;
            r_new.product  <= i_order_product;
            r_new.quantity <= i_order_quantity;
            r_new.prio     <= i_order_priority;
        end
        if (i_cmd.exec) begin
            r_slot         <= n_slot;
            r_popped_valid <= n_popped_valid;
            r_popped       <= n_popped;
            r_status       <= n_status;
            r_pending      <= spq_pkg::t_pend'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_popped_valid    = r_popped_valid;
    assign o_popped_product  = r_popped.product;
    assign o_popped_quantity = r_popped.quantity;
    assign o_popped_priority = r_popped.prio;
    assign o_status          = r_status;
    assign o_pending_count   = r_pending;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::t_cnt'(spq_pkg::QUEUE_DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_do_insert) |=> (r_count == $past(r_count) + spq_pkg::t_cnt'(1)))
        else $error("Accepted insert did not grow the queue by one.");

    a_pop_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_do_pop) |=> (r_popped_valid &&
            (r_popped.prio == $past(r_slot[0].prio))))
        else $error("Pop did not return the front entry.");

endmodule

// ===== hdl/stable_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded priority queue of orders kept sorted by priority, highest first,
// with equal priorities served in arrival order.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready   | i_kind, i_order_product,
//           |                           | i_order_quantity, i_order_priority
//  output   | o_out_valid / i_out_ready | o_popped_*, o_status,
//           |                           | o_pending_count
//
// Each transaction is captured into the holding registers, then executed as
// all queue slots compare and shift in parallel; the next one is taken only
// after it has executed. A result register decouples the two sides, so a new
// transaction is taken while a result waits. Execution stalls only while that
// register is still occupied. Synchronous reset empties the queue.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [spq_pkg::KIND_W-1:0]  i_kind,
    input  logic [spq_pkg::PROD_W-1:0]  i_order_product,
    input  logic [spq_pkg::QTY_W-1:0]   i_order_quantity,
    input  logic [spq_pkg::PRIO_W-1:0]  i_order_priority,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_popped_valid,
    output logic [spq_pkg::PROD_W-1:0]  o_popped_product,
    output logic [spq_pkg::QTY_W-1:0]   o_popped_quantity,
    output logic [spq_pkg::PRIO_W-1:0]  o_popped_priority,
    output logic [spq_pkg::STAT_W-1:0]  o_status,
    output logic [spq_pkg::PEND_W-1:0]  o_pending_count
);

    spq_pkg::t_cmd w_cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    spq_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_kind            (i_kind),
        .i_order_product   (i_order_product),
        .i_order_quantity  (i_order_quantity),
        .i_order_priority  (i_order_priority),
        .o_popped_valid    (o_popped_valid),
        .o_popped_product  (o_popped_product),
        .o_popped_quantity (o_popped_quantity),
        .o_popped_priority (o_popped_priority),
        .o_status          (o_status),
        .o_pending_count   (o_pending_count)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stable_priority_queue_unit. Orders go in over the
// input channel with random gaps, and results are taken with random stalls.
// A behavioral copy of the sorted queue predicts every result, and each
// result is checked field by field as it leaves the unit. The bench covers
// corner orders, the full and empty bounds, arrival order among equal
// priorities, clears, the unused kind value, and long random runs.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [spq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int                         CYCLE_LIMIT = 200000;

    typedef logic [spq_pkg::KIND_W-1:0] t_kind;
    typedef logic [spq_pkg::PROD_W-1:0] t_prod;
    typedef logic [spq_pkg::QTY_W-1:0]  t_qty;
    typedef logic [spq_pkg::PRIO_W-1:0] t_prio;

    typedef struct packed {
        t_prod prod;
        t_qty  qty;
        t_prio prio;
    } t_order;

    typedef struct packed {
        logic                       taken;
        t_prod                      prod;
        t_qty                       qty;
        t_prio                      prio;
        logic [spq_pkg::STAT_W-1:0] stat;
        spq_pkg::t_pend             pend;
    } t_reply;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    t_kind                       i_kind;
    t_prod                       i_order_product;
    t_qty                        i_order_quantity;
    t_prio                       i_order_priority;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic                        o_popped_valid;
    t_prod                       o_popped_product;
    t_qty                        o_popped_quantity;
    t_prio                       o_popped_priority;
    logic [spq_pkg::STAT_W-1:0]  o_status;
    spq_pkg::t_pend              o_pending_count;

    t_order held_orders[$];
    t_reply expected_replies[$];
    int     errors;
    int     cycle_count;
    int     orders_sent;
    int     replies_seen;
    int     full_refusals;
    int     empty_pops;
    int     served_pops;
    int     max_held;
    bit     gaps_on;
    bit     stalls_on;

    stable_priority_queue_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_order_product  (i_order_product),
        .i_order_quantity (i_order_quantity),
        .i_order_priority (i_order_priority),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_popped_valid   (o_popped_valid),
        .o_popped_product (o_popped_product),
        .o_popped_quantity(o_popped_quantity),
        .o_popped_priority(o_popped_priority),
        .o_status         (o_status),
        .o_pending_count  (o_pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_replies.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic t_reply queue_step(t_kind kind, t_order o);
        t_reply r;
        int     pos;
        r = '0;
        r.stat = spq_pkg::ST_OK;
        case (kind)
            spq_pkg::KIND_INSERT: begin
                if (held_orders.size() >= spq_pkg::QUEUE_DEPTH) begin
                    r.stat = spq_pkg::ST_FULL;
                    full_refusals++;
                end else begin
                    pos = 0;
                    while (pos < held_orders.size() && held_orders[pos].prio >= o.prio)
                        pos++;
                    held_orders.insert(pos, o);
                end
            end
            spq_pkg::KIND_POP: begin
                if (held_orders.size() == 0) begin
                    r.stat = spq_pkg::ST_EMPTY;
                    empty_pops++;
                end else begin
                    o = held_orders.pop_front();
                    r.taken = 1'b1;
                    r.prod  = o.prod;
                    r.qty   = o.qty;
                    r.prio  = o.prio;
                    served_pops++;
                end
            end
            spq_pkg::KIND_CLEAR: held_orders.delete();
            default: ;
        endcase
        if (held_orders.size() > max_held)
            max_held = held_orders.size();
        r.pend = spq_pkg::t_pend'(held_orders.size());
        return r;
    endfunction

    task automatic send_order(t_kind kind, t_prod prod, t_qty qty, t_prio prio);
        int     gap;
        t_order o;
        gap = gaps_on ? $urandom_range(0, 18) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= kind;
        i_order_product  <= prod;
        i_order_quantity <= qty;
        i_order_priority <= prio;
        do @(posedge i_clk); while (!o_in_ready);
        o.prod = prod;
        o.qty  = qty;
        o.prio = prio;
        expected_replies.push_back(queue_step(kind, o));
        orders_sent++;
    endtask

    task automatic drain_replies();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_order(int insert_pct);
        int    r;
        t_kind kind;
        t_prio prio;
        r = $urandom_range(0, 99);
        if (r < 3)
            kind = KIND_UNUSED;
        else if (r < 6)
            kind = spq_pkg::KIND_CLEAR;
        else if (r < 6 + insert_pct)
            kind = spq_pkg::KIND_INSERT;
        else
            kind = spq_pkg::KIND_POP;
        if ($urandom_range(0, 1))
            prio = t_prio'($urandom_range(0, 3));
        else
            prio = t_prio'($urandom);
        send_order(kind, t_prod'($urandom), t_qty'($urandom), prio);
    endtask

    always @(posedge i_clk) begin
        t_reply e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, status %0d count %0d", $time,
                         o_status, o_pending_count);
            end else begin
                e = expected_replies.pop_front();
                if (o_popped_valid !== e.taken) begin
                    errors++;
                    $display("%0t: popped_valid expected %0d actual %0d", $time,
                             e.taken, o_popped_valid);
                end
                if (o_popped_product !== e.prod) begin
                    errors++;
                    $display("%0t: popped_product expected %h actual %h", $time,
                             e.prod, o_popped_product);
                end
                if (o_popped_quantity !== e.qty) begin
                    errors++;
                    $display("%0t: popped_quantity expected %h actual %h", $time,
                             e.qty, o_popped_quantity);
                end
                if (o_popped_priority !== e.prio) begin
                    errors++;
                    $display("%0t: popped_priority expected %h actual %h", $time,
                             e.prio, o_popped_priority);
                end
                if (o_status !== e.stat) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             e.stat, o_status);
                end
                if (o_pending_count !== e.pend) begin
                    errors++;
                    $display("%0t: pending_count expected %0d actual %0d", $time,
                             e.pend, o_pending_count);
                end
            end
        end
    end

    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = stalls_on ? $urandom_range(0, 18) : 0;
            if (stall > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic test_corner_orders();
        send_order(spq_pkg::KIND_POP, '0, '0, '0);
        send_order(spq_pkg::KIND_CLEAR, '0, '0, '0);
        send_order(KIND_UNUSED, '1, '1, '1);
        send_order(spq_pkg::KIND_INSERT, '0, '0, '0);
        send_order(spq_pkg::KIND_INSERT, '1, '1, '1);
        send_order(spq_pkg::KIND_INSERT, 16'h1234, 16'h0001, 8'hFF);
        send_order(spq_pkg::KIND_INSERT, 16'h0005, 16'h0005, 8'h00);
        send_order(spq_pkg::KIND_INSERT, 16'hA5A5, 16'h5A5A, 8'h80);
        send_order(KIND_UNUSED, 16'h5A5A, 16'hA5A5, 8'h7F);
        repeat (4) send_order(spq_pkg::KIND_POP, '0, '0, '0);
        send_order(spq_pkg::KIND_CLEAR, '0, '0, '0);
        send_order(spq_pkg::KIND_POP, '0, '0, '0);
        drain_replies();
    endtask

    task automatic test_full_bound();
        repeat (spq_pkg::QUEUE_DEPTH)
            send_order(spq_pkg::KIND_INSERT, t_prod'($urandom), t_qty'($urandom),
                       t_prio'($urandom_range(0, 2)));
        send_order(spq_pkg::KIND_INSERT, '1, '1, '1);
        send_order(spq_pkg::KIND_INSERT, '0, '0, '0);
        repeat (spq_pkg::QUEUE_DEPTH + 1) send_order(spq_pkg::KIND_POP, '0, '0, '0);
        drain_replies();
    endtask

    task automatic test_random_traffic(int phases);
        int insert_pct;
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(0, 2))
                0: insert_pct = 80;
                1: insert_pct = 47;
                default: insert_pct = 20;
            endcase
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            repeat (25) random_order(insert_pct);
            if (p % 4 == 3)
                drain_replies();
        end
        drain_replies();
    endtask

    initial begin
        errors        = 0;
        cycle_count   = 0;
        orders_sent   = 0;
        replies_seen  = 0;
        full_refusals = 0;
        empty_pops    = 0;
        served_pops   = 0;
        max_held      = 0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_kind           = spq_pkg::KIND_INSERT;
        i_order_product  = '0;
        i_order_quantity = '0;
        i_order_priority = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_orders();
        test_full_bound();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_full_bound();
        test_random_traffic(17);

        repeat (10) @(posedge i_clk);
        $display("tb: %0d transactions sent, %0d results checked", orders_sent,
                 replies_seen);
        $display("tb: %0d served pops, %0d empty pops, %0d full refusals, peak %0d held",
                 served_pops, empty_pops, full_refusals, max_held);
        if (errors == 0 && expected_replies.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
